### design/iqsu_pkg.sv
// iqsu_pkg: shared types, constants and helper functions for the IQ sample unpacker.
// Used by every module of the block; depends on nothing else.
package iqsu_pkg;

   localparam int BYTE_W      = 8;
   localparam int SAMPLE_W    = 32;
   localparam int STORE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(STORE_DEPTH);
   localparam int NEED_W      = COUNT_W + 1;
   localparam int FMT_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index, taken from the word address bit of the configuration port
   localparam logic REG_IQ_FORMAT = 1'b0;

   localparam logic [SAMPLE_W-1:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [SAMPLE_W-1:0] Q31_MAX   = 32'h7FFF_FFFF;
   // 2^31/15 and 2^31/255, integer parts; the fraction is folded into the rounding term
   localparam logic [SAMPLE_W-1:0] UNIT4     = 32'h0888_8888;
   localparam logic [SAMPLE_W-1:0] UNIT8     = 32'h0080_8080;

   typedef enum logic [FMT_W-1:0] {
      FMT_CU4  = 4'd0,
      FMT_CS4  = 4'd1,
      FMT_CU8  = 4'd2,
      FMT_CS8  = 4'd3,
      FMT_CU12 = 4'd4,
      FMT_CS12 = 4'd5,
      FMT_CU16 = 4'd6,
      FMT_CS16 = 4'd7,
      FMT_CU32 = 4'd8,
      FMT_CS32 = 4'd9,
      FMT_CU64 = 4'd10,
      FMT_CS64 = 4'd11
   } iq_format_type;

   localparam logic [FMT_W-1:0] FMT_RESET = FMT_CU8;

   // aligned raw words of one complete sample, handed from gather to convert
   typedef struct packed {
      iq_format_type        fmt;
      logic [SAMPLE_W-1:0]  raw_i;
      logic [SAMPLE_W-1:0]  raw_q;
   } conv_req_type;

   // undefined codes run as cu8
   function automatic iq_format_type eff_format(input logic [FMT_W-1:0] code);
      iq_format_type f;
      if (code > FMT_CS64) begin
         f = FMT_CU8;
      end else begin
         f = iq_format_type'(code);
      end
      return f;
   endfunction

   function automatic logic [NEED_W-1:0] bytes_needed(input iq_format_type f);
      logic [NEED_W-1:0] n;
      case (f)
         FMT_CU4, FMT_CS4:   n = NEED_W'(1);
         FMT_CU8, FMT_CS8:   n = NEED_W'(2);
         FMT_CU12, FMT_CS12: n = NEED_W'(3);
         FMT_CU16, FMT_CS16: n = NEED_W'(4);
         FMT_CU32, FMT_CS32: n = NEED_W'(8);
         default:            n = NEED_W'(16);
      endcase
      return n;
   endfunction

endpackage

### design/iqsu_gather.sv
// iqsu_gather: byte counter and byte store; snapshots the aligned I/Q words of a
// complete sample into a register. Depends on iqsu_pkg.
module iqsu_gather (
   input  logic                         clock,
   input  logic                         reset,
   input  iqsu_pkg::iq_format_type      fmt,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [iqsu_pkg::BYTE_W-1:0]  in_byte,
   output logic                         snap_valid,
   input  logic                         snap_ready,
   output iqsu_pkg::conv_req_type       snap
);
   import iqsu_pkg::*;

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  byte_store_ff [STORE_DEPTH];
   logic [BYTE_W-1:0]  merged [STORE_DEPTH];
   logic               snap_valid_ff, snap_valid_in;
   conv_req_type       snap_ff, snap_in;
   logic [NEED_W-1:0]  count_next;
   logic               accept;
   logic               complete;

   // only the byte that finishes a sample needs room in the snapshot register
   assign in_ready   = !complete || !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign count_next = {1'b0, byte_count_ff} + NEED_W'(1);
   assign complete   = (count_next >= bytes_needed(fmt));

   // store contents as they stand once the incoming byte is in place
   always_comb begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         merged[k] = (byte_count_ff == COUNT_W'(k)) ? in_byte : byte_store_ff[k];
      end
   end

   always_comb begin
      snap_in.fmt = fmt;
      case (fmt)
         FMT_CU4, FMT_CS4: begin
            snap_in.raw_i = {merged[0][7:4], 28'd0};
            snap_in.raw_q = {merged[0][3:0], 28'd0};
         end
         FMT_CU8, FMT_CS8: begin
            snap_in.raw_i = {merged[0], 24'd0};
            snap_in.raw_q = {merged[1], 24'd0};
         end
         FMT_CU12, FMT_CS12: begin
            snap_in.raw_i = {merged[1][3:0], merged[0], 20'd0};
            snap_in.raw_q = {merged[2], merged[1][7:4], 20'd0};
         end
         FMT_CU16, FMT_CS16: begin
            snap_in.raw_i = {merged[1], merged[0], 16'd0};
            snap_in.raw_q = {merged[3], merged[2], 16'd0};
         end
         FMT_CU32, FMT_CS32: begin
            snap_in.raw_i = {merged[3], merged[2], merged[1], merged[0]};
            snap_in.raw_q = {merged[7], merged[6], merged[5], merged[4]};
         end
         default: begin
            // 64-bit words: keep the upper half of each
            snap_in.raw_i = {merged[7], merged[6], merged[5], merged[4]};
            snap_in.raw_q = {merged[15], merged[14], merged[13], merged[12]};
         end
      endcase
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      if (accept) begin
         byte_count_in = complete ? '0 : count_next[COUNT_W-1:0];
      end
      if (accept && complete) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_store_ff[byte_count_ff] <= in_byte;
      end
      if (accept && complete) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_ready |=> snap_valid_ff && $stable(snap_ff))
      else $error("snapshot changed while stalled");

   a_complete_restart: assert property (@(posedge clock) disable iff (reset)
      accept && complete |=> snap_valid_ff && byte_count_ff == '0)
      else $error("completed sample did not restart the count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !complete |=> byte_count_ff == $past(byte_count_ff) + COUNT_W'(1))
      else $error("byte count did not advance");

endmodule

### design/iqsu_unbias.sv
// iqsu_unbias: removes the mid bias of an unsigned 4-bit or 8-bit code and scales
// it to Q1.31 with round to nearest and +1.0 saturated. Depends on iqsu_pkg.
module iqsu_unbias (
   input  logic [iqsu_pkg::BYTE_W-1:0]   code,
   input  logic                          narrow,
   output logic [iqsu_pkg::SAMPLE_W-1:0] value
);
   import iqsu_pkg::*;

   logic                negative;
   logic [3:0]          mag4;
   logic [BYTE_W-1:0]   mag8;
   logic [SAMPLE_W-1:0] mag;

   // |2v - full| is odd; fold the sign into the low bits by inversion
   assign negative = ~code[7];
   assign mag4     = {code[6:4] ^ {3{~code[7]}}, 1'b1};
   assign mag8     = {code[6:0] ^ {7{~code[7]}}, 1'b1};

   // the fractional part of full scale over 2^31 always rounds to (m+1)/2
   always_comb begin
      if (narrow) begin
         mag = SAMPLE_W'(mag4) * UNIT4 + SAMPLE_W'(mag4[3:1]) + SAMPLE_W'(1);
      end else begin
         mag = SAMPLE_W'(mag8) * UNIT8 + SAMPLE_W'(mag8[7:1]) + SAMPLE_W'(1);
      end
      if (negative) begin
         value = '0 - mag;
      end else if (mag[SAMPLE_W-1]) begin
         value = Q31_MAX;
      end else begin
         value = mag;
      end
   end

endmodule

### design/iqsu_convert.sv
// iqsu_convert: turns aligned raw I/Q words into signed Q1.31 and holds them in the
// result register. Depends on iqsu_pkg and iqsu_unbias.
module iqsu_convert (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          snap_valid,
   output logic                          snap_ready,
   input  iqsu_pkg::conv_req_type        snap,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [iqsu_pkg::SAMPLE_W-1:0] out_i,
   output logic [iqsu_pkg::SAMPLE_W-1:0] out_q
);
   import iqsu_pkg::*;

   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_i_ff, out_i_in;
   logic [SAMPLE_W-1:0] out_q_ff, out_q_in;
   logic [SAMPLE_W-1:0] unb_i, unb_q;
   logic                narrow;
   logic                load;

   assign snap_ready = !out_valid_ff || out_ready;
   assign load       = snap_valid && snap_ready;
   assign narrow     = (snap.fmt == FMT_CU4);

   iqsu_unbias u_unbias_i (
      .code   (snap.raw_i[SAMPLE_W-1 -: BYTE_W]),
      .narrow (narrow),
      .value  (unb_i)
   );

   iqsu_unbias u_unbias_q (
      .code   (snap.raw_q[SAMPLE_W-1 -: BYTE_W]),
      .narrow (narrow),
      .value  (unb_q)
   );

   always_comb begin
      case (snap.fmt)
         FMT_CU4, FMT_CU8: begin
            out_i_in = unb_i;
            out_q_in = unb_q;
         end
         FMT_CS4, FMT_CS8, FMT_CS12, FMT_CS16, FMT_CS32, FMT_CS64: begin
            out_i_in = snap.raw_i;
            out_q_in = snap.raw_q;
         end
         default: begin
            // wide unsigned words: inverting the top bit removes the bias exactly
            out_i_in = snap.raw_i ^ SIGN_BIT;
            out_q_in = snap.raw_q ^ SIGN_BIT;
         end
      endcase
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_i_ff <= out_i_in;
         out_q_ff <= out_q_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_i     = out_i_ff;
   assign out_q     = out_q_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("loaded sample not presented");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !snap_valid && out_ready |=> !out_valid_ff)
      else $error("result presented without a sample");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(out_i_ff) && $stable(out_q_ff))
      else $error("result changed while stalled");

endmodule

### design/iq_sample_unpacker.sv
// iq_sample_unpacker: top level; configuration register, byte gathering and conversion.
// Depends on iqsu_pkg, iqsu_gather and iqsu_convert.
//
// Takes one raw byte per cycle with no bubbles while rsp_ready is held high. A sample
// completes after 1, 2, 3, 4, 8 or 16 bytes depending on the format register (4, 8,
// 12, 16, 32 or 64-bit I/Q pairs, little-endian, I first). Taking the last byte loads
// the snapshot register with the aligned words; the result register then loads the
// Q1.31 I/Q pair and rsp_valid rises. While results wait on rsp_ready, bytes that do
// not finish a sample are still taken; a byte that finishes one waits only while both
// the snapshot and result registers are full. The byte counter and 16-byte store take
// one byte a cycle, which sets the input rate. Codes 12 to 15 of the format register
// run as cu8. Change the format only while the block is idle.
module iq_sample_unpacker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_sample_i,
   output logic signed [31:0]              rsp_sample_q,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [iqsu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [iqsu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [iqsu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import iqsu_pkg::*;

   logic [FMT_W-1:0]    iq_format_ff, iq_format_in;
   iq_format_type       fmt;
   logic                csr_write;
   logic                snap_valid;
   logic                snap_ready;
   conv_req_type        snap;
   logic [SAMPLE_W-1:0] out_i, out_q;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_IQ_FORMAT);

   always_comb begin
      iq_format_in = iq_format_ff;
      if (csr_write) begin
         iq_format_in = csr_pwdata[FMT_W-1:0];
      end
      if (csr_paddr[2] == REG_IQ_FORMAT) begin
         csr_prdata = CSR_DATA_W'(iq_format_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iq_format_ff <= FMT_RESET;
      end else begin
         iq_format_ff <= iq_format_in;
      end
   end

   assign fmt = eff_format(iq_format_ff);

   iqsu_gather u_gather (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_byte    (req_data_byte),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   iqsu_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_i      (out_i),
      .out_q      (out_q)
   );

   assign rsp_sample_i = signed'(out_i);
   assign rsp_sample_q = signed'(out_q);

endmodule
